### rtl/core/multi_sensor_proximity_filter_macros.svh
// ---------------------------------------------------------------------------
// Proximity filter assertion macros
// Shared concurrent assertion forms for the proximity filter checkers.
// ---------------------------------------------------------------------------
`ifndef MULTI_SENSOR_PROXIMITY_FILTER_MACROS_SVH
`define MULTI_SENSOR_PROXIMITY_FILTER_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define MSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/msp_pkg.sv
// ---------------------------------------------------------------------------
// Proximity filter package
// Widths, constants, register indexes and shared types of the filter.
// ---------------------------------------------------------------------------
package msp_pkg;

   localparam int NUM_SENSORS = 8;
   localparam int ADDR_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   localparam int IDX_W    = 3;
   localparam int ECHO_W   = 16;
   localparam int DIST_W   = 9;
   localparam int MISS_W   = 8;
   localparam int PROX_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int CM_RAW_W = 11;
   localparam int CSR_W    = 9;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 24;

   // Division by 58 as a multiply by a rounded-up reciprocal; exact for 16-bit echoes.
   localparam int               ECHO_SHIFT = 22;
   localparam logic [16:0]      ECHO_RECIP = 17'd72316;
   localparam int               PROD_W     = ECHO_W + 17;

   localparam logic [DIST_W-1:0]  RESET_MAX_RANGE  = 9'd75;
   localparam logic [MISS_W-1:0]  RESET_MISS_LIMIT = 8'd10;
   localparam logic [DIST_W-1:0]  MIN_VALID_CM     = 9'd1;
   localparam logic [PROX_W-1:0]  PROX_NEAR        = 8'd255;

   // Scaled offset (d - 1) * 254 needs 17 bits; the quotient fits in 8.
   localparam int DIV_NUM_W = 17;
   localparam int DIV_Q_W   = 8;
   localparam int DIV_CNT_W = 3;

   typedef enum logic [0:0] {
      CSR_MAX_RANGE  = 1'b0,
      CSR_MISS_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0] held;
      logic [MISS_W-1:0] miss;
   } entry_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIST_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/core/msp_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module msp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/msp_prox_div.sv
// ---------------------------------------------------------------------------
// Proximity divider
// Restoring divider that yields one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module msp_prox_div (
   input  logic                clock,
   input  logic                reset,
   input  msp_pkg::div_req_type req,
   output msp_pkg::div_rsp_type rsp
);

   logic                            busy_ff;
   logic                            done_ff;
   logic [msp_pkg::DIV_CNT_W-1:0]   bit_ff;
   logic [msp_pkg::DIV_NUM_W-1:0]   rem_ff;
   logic [msp_pkg::DIST_W-1:0]      div_ff;
   logic [msp_pkg::DIV_Q_W-1:0]     quo_ff;
   logic [msp_pkg::DIV_NUM_W-1:0]   trial;
   logic                            fits;

   assign trial = msp_pkg::DIV_NUM_W'(div_ff) << bit_ff;
   assign fits  = (rem_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            bit_ff  <= '1;
         end else if (busy_ff) begin
            bit_ff <= bit_ff - 1'b1;
            if (bit_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.dividend;
         div_ff <= req.divisor;
         quo_ff <= '0;
      end else if (busy_ff && fits) begin
         rem_ff         <= rem_ff - trial;
         quo_ff[bit_ff] <= 1'b1;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/core/multi_sensor_proximity_filter.sv
// ---------------------------------------------------------------------------
// Multi-sensor proximity filter
// Median-of-three echo filter with per-sensor hold and nearest-distance select.
// ---------------------------------------------------------------------------
// The block takes one word at a time and returns one word for each. For an
// item that does not close a sweep, the accept cycle and the conversion state
// share one echo-to-cm multiplier, and the update state then does the
// read-modify-write of the sensor's held distance and miss run in the state
// memory. An item that closes a sweep then passes the prep state and waits in
// the map state for the proximity divider, or skips the divider when no
// sensor is valid or the range is below two. The state memory needs no
// clearing pass; per-entry valid bits make it read as zero after reset. A
// finished word waits in an output register, so a new item is taken while it
// is still unread, as long as that item's own result can wait.
// ---------------------------------------------------------------------------
module multi_sensor_proximity_filter (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sensor_index[2:0], echo_first[18:3], echo_second[34:19],
   // echo_third[50:35], zero fill above.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [msp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: held_distance[8:0], proximity[16:9], valid_count[20:17],
   // zero fill above. rsp_tlast carries sweep_done.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [msp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_addr,
   input  logic [msp_pkg::CSR_W-1:0]           csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_UPDATE,
      ST_PREP,
      ST_MAP,
      ST_OUT
   } state_type;

   localparam int DW = msp_pkg::DIST_W;
   localparam int AW = msp_pkg::ADDR_W;
   localparam int EW = msp_pkg::ECHO_W;

   state_type                        state_ff, state_in;
   logic                             conv_cnt_ff, conv_cnt_in;
   logic [DW-1:0]                    max_range_ff, max_range_in;
   logic [msp_pkg::MISS_W-1:0]       miss_limit_ff, miss_limit_in;
   logic [DW-1:0]                    nearest_ff, nearest_in;
   logic [msp_pkg::COUNT_W-1:0]      tally_ff, tally_in;
   logic [msp_pkg::NUM_SENSORS-1:0]  valid_ff, valid_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [msp_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [msp_pkg::IDX_W-1:0]        idx_ff;
   logic                             last_ff;
   logic [EW-1:0]                    echo_b_ff, echo_c_ff;
   logic [msp_pkg::CM_RAW_W-1:0]     cm_a_ff, cm_b_ff, cm_c_ff;
   logic [DW-1:0]                    held_ff;
   logic [msp_pkg::PROX_W-1:0]       prox_ff;
   logic [msp_pkg::COUNT_W-1:0]      count_ff;

   logic                             accept;
   logic                             slot_free;
   logic [msp_pkg::IDX_W-1:0]        req_idx;
   logic                             req_in_range;
   logic                             idx_in_range;
   logic [AW-1:0]                    req_addr;
   logic [AW-1:0]                    idx_addr;

   logic [EW-1:0]                    conv_src;
   logic [msp_pkg::PROD_W-1:0]       conv_prod;
   logic [msp_pkg::CM_RAW_W-1:0]     conv_cm;

   logic                             ram_we, ram_re;
   logic [$bits(msp_pkg::entry_type)-1:0] ram_rd_data;
   msp_pkg::entry_type               old_entry, new_entry;

   logic [DW-1:0]                    rd_a, rd_b, rd_c;
   logic [DW-1:0]                    lo_ab, hi_ab, hi_min_c, median;
   logic [msp_pkg::MISS_W-1:0]       miss_inc;
   logic [DW-1:0]                    held_out;
   logic [msp_pkg::COUNT_W-1:0]      tally_upd;
   logic [DW-1:0]                    nearest_upd;

   logic [DW-1:0]                    d_clamp, d_off;
   logic                             map_direct;
   msp_pkg::div_req_type             div_req;
   msp_pkg::div_rsp_type             div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign req_idx      = req_tdata[2:0];
   assign req_in_range = (32'(req_idx) < 32'(msp_pkg::NUM_SENSORS));
   assign idx_in_range = (32'(idx_ff) < 32'(msp_pkg::NUM_SENSORS));
   assign req_addr     = AW'(req_idx);
   assign idx_addr     = AW'(idx_ff);

   // Shared echo-to-cm unit: the first echo straight from the port, the rest from registers.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         conv_src = req_tdata[18:3];
      end else if (!conv_cnt_ff) begin
         conv_src = echo_b_ff;
      end else begin
         conv_src = echo_c_ff;
      end
   end

   assign conv_prod = msp_pkg::PROD_W'(conv_src) * msp_pkg::PROD_W'(msp_pkg::ECHO_RECIP);
   assign conv_cm   = msp_pkg::CM_RAW_W'(conv_prod >> msp_pkg::ECHO_SHIFT);

   msp_ram #(
      .WIDTH ($bits(msp_pkg::entry_type)),
      .DEPTH (msp_pkg::NUM_SENSORS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_addr),
      .wr_data (new_entry),
      .rd_en   (ram_re),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // An entry never written since reset reads as zero.
   assign old_entry = rd_valid_ff ? msp_pkg::entry_type'(ram_rd_data) : '0;

   // Readings beyond the range count as no echo; zero already is one.
   assign rd_a = (cm_a_ff > msp_pkg::CM_RAW_W'(max_range_ff)) ? '0 : cm_a_ff[DW-1:0];
   assign rd_b = (cm_b_ff > msp_pkg::CM_RAW_W'(max_range_ff)) ? '0 : cm_b_ff[DW-1:0];
   assign rd_c = (cm_c_ff > msp_pkg::CM_RAW_W'(max_range_ff)) ? '0 : cm_c_ff[DW-1:0];

   assign lo_ab    = (rd_a < rd_b) ? rd_a : rd_b;
   assign hi_ab    = (rd_a < rd_b) ? rd_b : rd_a;
   assign hi_min_c = (hi_ab < rd_c) ? hi_ab : rd_c;
   assign median   = (lo_ab > hi_min_c) ? lo_ab : hi_min_c;

   assign miss_inc = (old_entry.miss == '1) ? old_entry.miss : old_entry.miss + 1'b1;

   always_comb begin
      if (median != '0) begin
         new_entry.held = median;
         new_entry.miss = '0;
      end else begin
         new_entry.miss = miss_inc;
         new_entry.held = (miss_inc >= miss_limit_ff) ? '0 : old_entry.held;
      end
   end

   assign held_out    = idx_in_range ? new_entry.held : '0;
   assign tally_upd   = ((held_out != '0) && (tally_ff != '1)) ? tally_ff + 1'b1 : tally_ff;
   assign nearest_upd = ((held_out != '0) && (held_out < nearest_ff)) ? held_out : nearest_ff;

   // Mapping: clamp the nearest distance into [1, max] and scale by 254.
   always_comb begin
      if (nearest_ff < msp_pkg::MIN_VALID_CM) begin
         d_clamp = msp_pkg::MIN_VALID_CM;
      end else if (nearest_ff > max_range_ff) begin
         d_clamp = max_range_ff;
      end else begin
         d_clamp = nearest_ff;
      end
   end

   assign d_off      = d_clamp - msp_pkg::MIN_VALID_CM;
   assign map_direct = (tally_ff == '0) || (max_range_ff < 9'd2);

   always_comb begin
      div_req.start    = (state_ff == ST_PREP) && !map_direct;
      div_req.dividend = (msp_pkg::DIV_NUM_W'(d_off) << 8) - (msp_pkg::DIV_NUM_W'(d_off) << 1);
      div_req.divisor  = max_range_ff - msp_pkg::MIN_VALID_CM;
   end

   msp_prox_div u_prox_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      conv_cnt_in   = conv_cnt_ff;
      max_range_in  = max_range_ff;
      miss_limit_in = miss_limit_ff;
      nearest_in    = nearest_ff;
      tally_in      = tally_ff;
      valid_in      = valid_ff;
      rd_valid_in   = rd_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (csr_we) begin
         case (msp_pkg::csr_index_type'(csr_addr))
            msp_pkg::CSR_MAX_RANGE: begin
               max_range_in = csr_wdata;
            end
            msp_pkg::CSR_MISS_LIMIT: begin
               miss_limit_in = csr_wdata[msp_pkg::MISS_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ram_re      = 1'b1;
               rd_valid_in = req_in_range && valid_ff[req_addr];
               conv_cnt_in = 1'b0;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            conv_cnt_in = !conv_cnt_ff;
            if (conv_cnt_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (idx_in_range) begin
               ram_we             = 1'b1;
               valid_in[idx_addr] = 1'b1;
            end
            tally_in   = tally_upd;
            nearest_in = nearest_upd;
            if (last_ff) begin
               state_in = ST_PREP;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = msp_pkg::RSP_TDATA_W'(held_out);
               rsp_last_in  = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PREP: begin
            // The sweep closes here; the next one starts from the current range.
            nearest_in = max_range_ff;
            tally_in   = '0;
            state_in   = map_direct ? ST_OUT : ST_MAP;
         end
         ST_MAP: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = msp_pkg::RSP_TDATA_W'({count_ff, prox_ff, held_ff});
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         conv_cnt_ff   <= 1'b0;
         max_range_ff  <= msp_pkg::RESET_MAX_RANGE;
         miss_limit_ff <= msp_pkg::RESET_MISS_LIMIT;
         nearest_ff    <= msp_pkg::RESET_MAX_RANGE;
         tally_ff      <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         conv_cnt_ff   <= conv_cnt_in;
         max_range_ff  <= max_range_in;
         miss_limit_ff <= miss_limit_in;
         nearest_ff    <= nearest_in;
         tally_ff      <= tally_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Item payload and per-item results.
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= req_idx;
         last_ff   <= req_tlast;
         echo_b_ff <= req_tdata[34:19];
         echo_c_ff <= req_tdata[50:35];
         cm_a_ff   <= conv_cm;
      end
      if (state_ff == ST_CONV) begin
         if (!conv_cnt_ff) begin
            cm_b_ff <= conv_cm;
         end else begin
            cm_c_ff <= conv_cm;
         end
      end
      if (state_ff == ST_UPDATE) begin
         held_ff  <= held_out;
         prox_ff  <= '0;
         count_ff <= '0;
      end
      if (state_ff == ST_PREP) begin
         count_ff <= tally_ff;
         prox_ff  <= (tally_ff == '0) ? '0 : msp_pkg::PROX_NEAR;
      end
      if ((state_ff == ST_MAP) && div_rsp.done) begin
         prox_ff <= msp_pkg::PROX_NEAR - div_rsp.quotient;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/msp_checker.sv
// ---------------------------------------------------------------------------
// Proximity filter port checker
// Watches the top-level ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_sensor_proximity_filter_macros.svh"

module msp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [msp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // A stalled result word keeps its contents.
   `MSP_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "result word changed while stalled")

   // Words that do not close a sweep carry no proximity and no count.
   `MSP_ASSERT(a_mid_sweep_zero, (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[20:9] == 12'd0), "mid-sweep word carries proximity or count")

   // At sweep end, proximity is zero exactly when no sensor was valid.
   `MSP_ASSERT(a_prox_vs_count, (rsp_tvalid && rsp_tlast) |-> ((rsp_tdata[16:9] == 8'd0) == (rsp_tdata[20:17] == 4'd0)), "proximity disagrees with valid count")

   // Items are worked one at a time, so an accepted word closes the input for a while.
   `MSP_ASSERT(a_one_at_a_time, (req_tvalid && req_tready) |=> !req_tready, "input accepted on consecutive cycles")

endmodule

bind multi_sensor_proximity_filter msp_checker u_msp_checker (.*);

### test/tb_multi_sensor_proximity_filter.sv
// ---------------------------------------------------------------------------
// Proximity filter testbench
// Drives echo-time words into the filter and predicts every result word from
// a cycle-free model of the median, hold, miss-run and proximity logic. Each
// result is checked field by field against the oldest prediction. Directed
// tests cover field extremes, the miss limits, the range extremes, a range
// change inside a sweep and a long miss run. Random sweeps then run under
// several register settings with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_sensor_proximity_filter;

   localparam int US_PER_CM     = 58;
   localparam int MAX_ECHO_CM   = 1129;
   localparam int PROX_SPAN     = 254;
   localparam int TALLY_MAX     = 15;
   localparam int MISS_MAX      = 255;
   localparam int REQ_FILL_W    = msp_pkg::REQ_TDATA_W - msp_pkg::IDX_W - 3 * msp_pkg::ECHO_W;
   localparam int PROX_LSB      = msp_pkg::DIST_W;
   localparam int COUNT_LSB     = msp_pkg::DIST_W + msp_pkg::PROX_W;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 145;
   localparam int MISS_RUN_LEN  = 258;

   typedef struct packed {
      logic [msp_pkg::IDX_W-1:0]  sensor;
      logic [msp_pkg::ECHO_W-1:0] echo_a;
      logic [msp_pkg::ECHO_W-1:0] echo_b;
      logic [msp_pkg::ECHO_W-1:0] echo_c;
      logic                       last;
   } sensor_reading_type;

   typedef struct packed {
      logic [msp_pkg::DIST_W-1:0]  held;
      logic                        done;
      logic [msp_pkg::PROX_W-1:0]  prox;
      logic [msp_pkg::COUNT_W-1:0] count;
   } filter_word_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [msp_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [msp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic [0:0]                      csr_addr   = '0;
   logic [msp_pkg::CSR_W-1:0]       csr_wdata  = '0;

   // Filter state as the hardware should hold it.
   logic [msp_pkg::DIST_W-1:0]  range_cm    = msp_pkg::RESET_MAX_RANGE;
   logic [msp_pkg::MISS_W-1:0]  miss_limit  = msp_pkg::RESET_MISS_LIMIT;
   logic [msp_pkg::DIST_W-1:0]  held_cm  [msp_pkg::NUM_SENSORS];
   logic [msp_pkg::MISS_W-1:0]  miss_run [msp_pkg::NUM_SENSORS];
   logic [msp_pkg::DIST_W-1:0]  nearest_cm  = msp_pkg::RESET_MAX_RANGE;
   logic [msp_pkg::COUNT_W-1:0] valid_tally = '0;

   filter_word_type expected_words[$];
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              stall_left = 0;
   bit              idle_on = 1'b1;

   multi_sensor_proximity_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic int echo_cm(logic [msp_pkg::ECHO_W-1:0] echo);
      int cm;
      cm = int'(echo) / US_PER_CM;
      return (cm > int'(range_cm)) ? 0 : cm;
   endfunction

   function automatic int median3(int a, int b, int c);
      if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
      if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
      return c;
   endfunction

   function automatic logic [msp_pkg::PROX_W-1:0] proximity_of(int d);
      int lo;
      int hi;
      lo = int'(msp_pkg::MIN_VALID_CM);
      hi = int'(range_cm);
      if (hi < 2) return msp_pkg::PROX_NEAR;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      return msp_pkg::PROX_W'(int'(msp_pkg::PROX_NEAR) - ((d - lo) * PROX_SPAN) / (hi - lo));
   endfunction

   function automatic filter_word_type predict_word(sensor_reading_type r);
      filter_word_type w;
      int              mid;
      w = '0;
      if (r.sensor < msp_pkg::NUM_SENSORS) begin
         mid = median3(echo_cm(r.echo_a), echo_cm(r.echo_b), echo_cm(r.echo_c));
         if (mid != 0) begin
            held_cm[r.sensor]  = msp_pkg::DIST_W'(mid);
            miss_run[r.sensor] = '0;
         end else begin
            if (miss_run[r.sensor] != MISS_MAX) miss_run[r.sensor]++;
            if (miss_run[r.sensor] >= miss_limit) held_cm[r.sensor] = '0;
         end
         w.held = held_cm[r.sensor];
         if (w.held != 0) begin
            if (valid_tally != TALLY_MAX) valid_tally++;
            if (w.held < nearest_cm) nearest_cm = w.held;
         end
      end
      w.done = r.last;
      if (r.last) begin
         w.count     = valid_tally;
         w.prox      = (valid_tally == 0) ? '0 : proximity_of(nearest_cm);
         nearest_cm  = range_cm;
         valid_tally = '0;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Called at a rising edge; returns at the edge where the word is accepted,
   // with req_tvalid still high so the next word can follow without a gap.
   task automatic send_reading(input logic [msp_pkg::IDX_W-1:0] sensor,
                               input logic [msp_pkg::ECHO_W-1:0] a, b, c,
                               input logic last);
      sensor_reading_type r;
      r = '{sensor, a, b, c, last};
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_FILL_W{1'b0}}, c, b, a, sensor};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(predict_word(r));
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input msp_pkg::csr_index_type index,
                                 input logic [msp_pkg::CSR_W-1:0] value);
      wait_all_results();
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (index)
         msp_pkg::CSR_MAX_RANGE:  range_cm   = value[msp_pkg::DIST_W-1:0];
         msp_pkg::CSR_MISS_LIMIT: miss_limit = value[msp_pkg::MISS_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [msp_pkg::ECHO_W-1:0] clamp_echo(int us);
      return (us > 65535) ? 16'hFFFF : us[msp_pkg::ECHO_W-1:0];
   endfunction

   // An echo that reads as no detection: a timeout, under one centimeter, or
   // beyond the current range.
   function automatic logic [msp_pkg::ECHO_W-1:0] miss_echo();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return clamp_echo($urandom_range(1, US_PER_CM - 1));
         default: return clamp_echo((int'(range_cm) + 1 + $urandom_range(0, 30)) * US_PER_CM
                                    + $urandom_range(0, US_PER_CM - 1));
      endcase
   endfunction

   function automatic logic [msp_pkg::ECHO_W-1:0] echo_near(int base_cm);
      int cm;
      if ($urandom_range(0, 5) == 0) return miss_echo();
      cm = base_cm + int'($urandom_range(0, 6)) - 3;
      if (cm < 1) cm = 1;
      return clamp_echo(cm * US_PER_CM + $urandom_range(0, US_PER_CM - 1));
   endfunction

   task automatic send_random_reading(input logic [msp_pkg::IDX_W-1:0] sensor,
                                      input logic last);
      int hi;
      int base;
      int kind;
      hi   = (range_cm < 1) ? 1 : ((range_cm > MAX_ECHO_CM) ? MAX_ECHO_CM : range_cm);
      base = $urandom_range(1, hi);
      kind = $urandom_range(0, 9);
      if (kind < 7)
         send_reading(sensor, echo_near(base), echo_near(base), echo_near(base), last);
      else if (kind == 7)
         send_reading(sensor, miss_echo(), miss_echo(), miss_echo(), last);
      else
         send_reading(sensor, msp_pkg::ECHO_W'($urandom_range(0, 65535)),
                      msp_pkg::ECHO_W'($urandom_range(0, 65535)),
                      msp_pkg::ECHO_W'($urandom_range(0, 65535)), last);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_settings();
      send_reading(3'd0, 16'd58, 16'd58, 16'd58, 1'b0);
      send_reading(3'd1, 16'd4350, 16'd4407, 16'd4350, 1'b0);
      send_reading(3'd2, 16'd4408, 16'd0, 16'hFFFF, 1'b0);
      send_reading(3'd3, 16'd57, 16'd0, 16'd116, 1'b0);
      send_reading(3'd5, 16'd580, 16'd2320, 16'd1160, 1'b0);
      send_reading(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_reading(3'd1, 16'd4350, 16'd4350, 16'd4351, 1'b1);
   endtask

   task automatic test_miss_limits();
      write_register(msp_pkg::CSR_MISS_LIMIT, 9'd2);
      send_reading(3'd7, 16'd1160, 16'd1160, 16'd1160, 1'b0);
      send_reading(3'd7, 16'd0, 16'd0, 16'd0, 1'b0);
      send_reading(3'd7, 16'd0, 16'd57, 16'd0, 1'b1);
      // A limit of zero clears the held distance on the first miss.
      write_register(msp_pkg::CSR_MISS_LIMIT, 9'd0);
      send_reading(3'd6, 16'd2900, 16'd2900, 16'd2900, 1'b0);
      send_reading(3'd6, 16'd0, 16'd0, 16'd0, 1'b1);
   endtask

   task automatic test_range_extremes();
      write_register(msp_pkg::CSR_MISS_LIMIT, 9'd255);
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd1);
      send_reading(3'd0, 16'd58, 16'd58, 16'd115, 1'b1);
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd0);
      send_reading(3'd1, 16'd58, 16'd0, 16'd116, 1'b1);
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd511);
      send_reading(3'd2, 16'hFFFF, 16'd29638, 16'd29638, 1'b0);
      send_reading(3'd4, 16'hFFFF, 16'd29696, 16'hFFFF, 1'b1);
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd2);
      send_reading(3'd3, 16'd116, 16'd116, 16'd174, 1'b1);
   endtask

   // Shrinking the range inside a sweep clamps the nearest distance seen so far.
   task automatic test_range_mid_sweep();
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd400);
      send_reading(3'd4, 16'd23200, 16'd23200, 16'd23257, 1'b0);
      send_reading(3'd5, 16'd11600, 16'd11600, 16'd11600, 1'b0);
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd100);
      send_reading(3'd6, 16'd0, 16'd0, 16'd0, 1'b1);
   endtask

   // A miss run long enough to reach the counter's ceiling at the widest limit.
   task automatic test_long_miss_run();
      int k;
      write_register(msp_pkg::CSR_MAX_RANGE, 9'd400);
      write_register(msp_pkg::CSR_MISS_LIMIT, 9'd255);
      send_reading(3'd5, 16'd3000, 16'd3000, 16'd3000, 1'b0);
      for (k = 0; k < MISS_RUN_LEN; k++)
         send_reading(3'd5, miss_echo(), miss_echo(), miss_echo(),
                      $urandom_range(0, 15) == 0);
      send_reading(3'd5, 16'd3000, 16'd3100, 16'd2900, 1'b1);
   endtask

   task automatic test_random_sweeps();
      logic [msp_pkg::CSR_W-1:0] ranges [PHASES];
      logic [msp_pkg::CSR_W-1:0] limits [PHASES];
      int                        phase;
      int                        sent;
      int                        len;
      int                        k;
      bit                        long_sweep;
      ranges = '{9'd75, 9'd2, 9'd400, 9'd511, 9'd0, 9'd1, 9'd150, 9'd30};
      limits = '{9'd10, 9'd1, 9'd255, 9'd0, 9'd3, 9'd7, 9'd2, 9'd5};
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase >= PHASES - 2) begin
            ranges[phase] = msp_pkg::CSR_W'($urandom_range(2, 400));
            limits[phase] = msp_pkg::CSR_W'($urandom_range(1, 255));
         end
         write_register(msp_pkg::CSR_MAX_RANGE, ranges[phase]);
         write_register(msp_pkg::CSR_MISS_LIMIT, limits[phase]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            idle_on    = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            // Long sweeps repeat sensors and can push the valid tally to its ceiling.
            long_sweep = ($urandom_range(0, 7) == 0);
            len = long_sweep ? $urandom_range(16, 20) : $urandom_range(1, msp_pkg::NUM_SENSORS);
            for (k = 0; k < len; k++) begin
               send_random_reading(msp_pkg::IDX_W'(long_sweep ?
                                      $urandom_range(0, msp_pkg::NUM_SENSORS - 1) : k),
                                   k == len - 1);
               sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking, receiver stalls and watchdog
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      filter_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("held_distance", want.held, rsp_tdata[msp_pkg::DIST_W-1:0]);
            check_field("sweep_done", want.done, rsp_tlast);
            check_field("proximity", want.prox, rsp_tdata[PROX_LSB +: msp_pkg::PROX_W]);
            check_field("valid_count", want.count, rsp_tdata[COUNT_LSB +: msp_pkg::COUNT_W]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      foreach (held_cm[i]) begin
         held_cm[i]  = '0;
         miss_run[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_miss_limits();
      test_range_extremes();
      test_range_mid_sweep();
      test_long_miss_run();
      test_random_sweeps();

      wait_all_results();
      idle_on = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_words.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
